### rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared types for the multiword modular adder
// Request and result payloads, sequencer states and the control and status
// groups passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mma_pkg;

    // Width of the word fields on the ports.
    localparam int unsigned DATA_BITS = 32;

    typedef struct packed {
        logic [DATA_BITS-1:0] a_word;
        logic [DATA_BITS-1:0] b_word;
        logic [DATA_BITS-1:0] mod_word;
        logic                 last;
    } t_req;

    typedef struct packed {
        logic [DATA_BITS-1:0] res_word;
        logic                 final_word;
        logic                 reduced;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_EMIT
    } t_state;

    // Sequencer to datapath.
    typedef struct packed {
        logic wr_en;     // write sum and modulus word to the store
        logic alu_sub;   // shared unit subtracts rather than adds
        logic alu_cin;   // carry in, or borrow in when subtracting
        logic out_load;  // load the result register
        logic out_final; // result being loaded is the last of the run
        logic reduce;    // modulus is subtracted in this run
        logic busy;
    } t_ctrl;

    // Shared unit to sequencer.
    typedef struct packed {
        logic cout;      // carry out, or borrow out when subtracting
        logic gt;        // result above the compare operand
        logic lt;        // result below the compare operand
    } t_alu_flags;

endpackage

### rtl/mma_alu.sv
// ----------------------------------------------------------------------------
// mma_alu: shared word adder and subtractor
// One word-wide add or subtract with carry, plus a compare of the result
// against a third operand, used both while loading and while emitting.
// ----------------------------------------------------------------------------
module mma_alu
    import mma_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                 i_sub,
    input  logic                 i_cin,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    input  logic [WORD_BITS-1:0] i_z,
    output logic [WORD_BITS-1:0] o_r,
    output t_alu_flags           o_flags
);

    logic [WORD_BITS-1:0] y_op;
    logic                 c_op;
    logic [WORD_BITS:0]   total;

    // Subtraction is done as x + ~y + ~borrow_in; the carry out is then the
    // inverse of the borrow out.
    always_comb begin
        y_op          = i_sub ? ~i_y : i_y;
        c_op          = i_sub ? ~i_cin : i_cin;
        total         = {1'b0, i_x} + {1'b0, y_op} + {{WORD_BITS{1'b0}}, c_op};
        o_r           = total[WORD_BITS-1:0];
        o_flags.cout  = i_sub ? ~total[WORD_BITS] : total[WORD_BITS];
        o_flags.gt    = o_r > i_z;
        o_flags.lt    = o_r < i_z;
    end

endmodule

### rtl/mma_store.sv
// ----------------------------------------------------------------------------
// mma_store: sum and modulus word memories
// Two word memories sharing one write address and one read address, with
// registered read data.
// ----------------------------------------------------------------------------
module mma_store
    import mma_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned NUM_WORDS = 8,
    localparam int unsigned IDX_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_BITS-1:0]  i_wr_idx,
    input  logic [WORD_BITS-1:0] i_wr_sum,
    input  logic [WORD_BITS-1:0] i_wr_mod,
    input  logic [IDX_BITS-1:0]  i_rd_idx,
    output logic [WORD_BITS-1:0] o_rd_sum,
    output logic [WORD_BITS-1:0] o_rd_mod
);

    logic [WORD_BITS-1:0] r_sum_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_mod_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_sum;
    logic [WORD_BITS-1:0] r_rd_mod;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sum_mem[i_wr_idx] <= i_wr_sum;
            r_mod_mem[i_wr_idx] <= i_wr_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sum <= r_sum_mem[i_rd_idx];
        r_rd_mod <= r_mod_mem[i_rd_idx];
    end

    assign o_rd_sum = r_rd_sum;
    assign o_rd_mod = r_rd_mod;

endmodule

### rtl/mma_seq.sv
// ----------------------------------------------------------------------------
// mma_seq: load and emit sequencer
// Counts loaded words, keeps the running carry and the sum-versus-modulus
// flag, then steps the shared unit through the stored words.
// ----------------------------------------------------------------------------
module mma_seq
    import mma_pkg::*;
#(
    parameter int unsigned NUM_WORDS = 8,
    localparam int unsigned IDX_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int unsigned CNT_BITS = $clog2(NUM_WORDS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_last,
    input  t_alu_flags          i_flags,
    output t_ctrl               o_ctrl,
    output logic [IDX_BITS-1:0] o_wr_idx,
    output logic [IDX_BITS-1:0] o_rd_idx
);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;     // words loaded in this run
    logic [CNT_BITS-1:0] r_num, n_num;     // words to emit
    logic [CNT_BITS-1:0] r_k, n_k;         // word being emitted
    logic                r_carry, n_carry;
    logic                r_ge, n_ge;
    logic                r_red, n_red;
    logic                r_borrow, n_borrow;
    logic [CNT_BITS-1:0] k_next;
    logic                ge_new;
    logic                accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_num    <= '0;
            r_k      <= '0;
            r_carry  <= 1'b0;
            r_ge     <= 1'b1;
            r_red    <= 1'b0;
            r_borrow <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_num    <= n_num;
            r_k      <= n_k;
            r_carry  <= n_carry;
            r_ge     <= n_ge;
            r_red    <= n_red;
            r_borrow <= n_borrow;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_num    = r_num;
        n_k      = r_k;
        n_carry  = r_carry;
        n_ge     = r_ge;
        n_red    = r_red;
        n_borrow = r_borrow;
        k_next   = CNT_BITS'(r_k + 1'b1);
        accept   = i_start && (r_state == S_IDLE);
        // A differing higher word decides the comparison.
        ge_new   = i_flags.gt ? 1'b1 : (i_flags.lt ? 1'b0 : r_ge);

        o_ctrl          = '0;
        o_ctrl.reduce   = r_red;
        o_ctrl.busy     = (r_state != S_IDLE);
        o_wr_idx        = r_cnt[IDX_BITS-1:0];
        o_rd_idx        = r_k[IDX_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_ctrl.alu_cin = r_carry;
                o_ctrl.wr_en   = accept;
                if (accept) begin
                    n_carry = i_flags.cout;
                    n_ge    = ge_new;
                    n_cnt   = CNT_BITS'(r_cnt + 1'b1);
                    // A word that fills the store closes the run as well.
                    if (i_last || (r_cnt == CNT_BITS'(NUM_WORDS - 1))) begin
                        n_state  = S_PREP;
                        n_num    = CNT_BITS'(r_cnt + 1'b1);
                        n_red    = i_flags.cout | ge_new;
                        n_k      = '0;
                        n_borrow = 1'b0;
                        n_cnt    = '0;
                        n_carry  = 1'b0;
                        n_ge     = 1'b1;
                    end
                end
            end
            S_PREP: begin
                // Word zero is being read from the store.
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_ctrl.alu_sub   = 1'b1;
                o_ctrl.alu_cin   = r_borrow;
                o_ctrl.out_load  = 1'b1;
                o_ctrl.out_final = (k_next == r_num);
                o_rd_idx         = k_next[IDX_BITS-1:0];
                n_borrow         = i_flags.cout;
                n_k              = k_next;
                if (k_next == r_num) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/multiword_modular_adder_top.sv
// ----------------------------------------------------------------------------
// multiword_modular_adder_top: multiword (a + b) mod p
// Loads the operands one word per request, least significant first, and then
// emits the reduced sum one word per cycle, least significant first.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  -----------------------------
//  request   in         start high while busy low  i_req: a, b, p words and last
//  result    out        o_res_valid, one cycle     o_res: word, final, reduced
//
// While the operands load, a request is taken whenever start is high and
// busy low, so words may be offered back to back until the last one. The
// last word (or the word that fills the store) raises busy through a read
// state and then an emit state that steps through the stored words; the
// shared word adder and the single read port of the word store keep the
// load and emit phases apart. Results follow the emit cycles by one register
// stage. The receiver cannot stall, and a new request may be accepted while
// the final result word is still on the port. Reset is synchronous and
// active low; it clears the sequencer and the result strobe but not the word
// store, whose entries are always written before they are read.
//
module multiword_modular_adder_top
    import mma_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned NUM_WORDS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_res_valid,
    output t_res o_res
);

    localparam int unsigned IDX_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    t_ctrl                ctrl;
    t_alu_flags           flags;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [IDX_BITS-1:0]  rd_idx;
    logic [WORD_BITS-1:0] rd_sum;
    logic [WORD_BITS-1:0] rd_mod;
    logic [WORD_BITS-1:0] alu_x;
    logic [WORD_BITS-1:0] alu_y;
    logic [WORD_BITS-1:0] alu_z;
    logic [WORD_BITS-1:0] alu_r;
    logic [WORD_BITS-1:0] res_w;
    t_res                 n_res;
    t_res                 r_res;
    logic                 r_res_valid;

    // The sequencer steps through loading and then emitting the run.
    mma_seq #(
        .NUM_WORDS (NUM_WORDS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_req.last),
        .i_flags  (flags),
        .o_ctrl   (ctrl),
        .o_wr_idx (wr_idx),
        .o_rd_idx (rd_idx)
    );

    // While loading, the shared unit adds the incoming a and b words with the
    // running carry and compares the sum word with the incoming p word. While
    // emitting, it subtracts the stored p word from the stored sum word with
    // the running borrow.
    always_comb begin
        alu_x = ctrl.alu_sub ? rd_sum : WORD_BITS'(i_req.a_word);
        alu_y = ctrl.alu_sub ? rd_mod : WORD_BITS'(i_req.b_word);
        alu_z = WORD_BITS'(i_req.mod_word);
    end

    mma_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_sub   (ctrl.alu_sub),
        .i_cin   (ctrl.alu_cin),
        .i_x     (alu_x),
        .i_y     (alu_y),
        .i_z     (alu_z),
        .o_r     (alu_r),
        .o_flags (flags)
    );

    // The store keeps the sum words and the p words of the current run.
    mma_store #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (ctrl.wr_en),
        .i_wr_idx (wr_idx),
        .i_wr_sum (alu_r),
        .i_wr_mod (alu_z),
        .i_rd_idx (rd_idx),
        .o_rd_sum (rd_sum),
        .o_rd_mod (rd_mod)
    );

    // When no reduction is due the stored sum word passes through unchanged.
    always_comb begin
        res_w            = ctrl.reduce ? alu_r : rd_sum;
        n_res.res_word   = DATA_BITS'(res_w);
        n_res.final_word = ctrl.out_final;
        n_res.reduced    = ctrl.reduce;
    end

    // Result register: each word is shown for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= ctrl.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_res <= n_res;
        end
    end

    assign busy        = ctrl.busy;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### rtl/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker: port-level checks for the multiword modular adder
// Watches the request and result ports over time and is bound to the top
// level.
// ----------------------------------------------------------------------------
module mma_checker
    import mma_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_req i_req,
    input logic busy,
    input logic o_res_valid,
    input t_res o_res
);

    // Accepting the last word raises busy.
    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.last) |=> busy)
        else $error("last request did not start the emit phase");

    // Result words of one run come in consecutive cycles.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.final_word) |=> o_res_valid)
        else $error("gap inside a run of result words");

    // The final word closes the run.
    a_final_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.final_word) |=> !o_res_valid)
        else $error("result word after the final word");

    // The reduction decision is the same on every word of a run.
    a_reduced_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.final_word) |=> $stable(o_res.reduced))
        else $error("reduced flag changed within a run");

    // A result is only produced out of the emit phase.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result word without an emit phase");

endmodule

bind multiword_modular_adder_top mma_checker u_mma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_req       (i_req),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
